FILE: hdl/arc_pkg.sv
// Shared constants and types for the audio rate converter.
// No dependencies; imported by every module of the block.
package arc_pkg;

  localparam int unsigned FRAC_BITS   = 32;
  localparam int unsigned RATE_BITS   = 24;
  localparam int unsigned MAX_OUTPUTS = 64;
  localparam int unsigned SAMPLE_W    = 16;

  // Quotient of rate << FRAC_BITS by a rate never needs more than this.
  localparam int unsigned STEP_W   = RATE_BITS + FRAC_BITS;
  localparam int unsigned PHASE_W  = STEP_W + 1;
  localparam int unsigned CNT_W    = $clog2(MAX_OUTPUTS + 1);
  localparam int unsigned DIV_CNT_W = $clog2(STEP_W + 1);

  localparam longint unsigned ONE_VAL = longint'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] STEP_MIN =
    STEP_W'((ONE_VAL + longint'(MAX_OUTPUTS) - 1) / longint'(MAX_OUTPUTS));
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(ONE_VAL);
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(ONE_VAL);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = RATE_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_RATE    = 2'd0,
    REG_OUTPUT_RATE   = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_INTERP_MODE   = 2'd3
  } reg_idx_e;

  localparam logic [1:0] CHAN_MONO = 2'd1;

  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);
  localparam logic [1:0]           CHAN_RESET = 2'd2;

  typedef enum logic {
    MODE_NEAREST = 1'b0,
    MODE_LINEAR  = 1'b1
  } interp_mode_e;

  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_RESTART = 1'b1
  } item_kind_e;

  // Request to the step divider.
  typedef struct packed {
    logic                 start;
    logic [RATE_BITS-1:0] num;
    logic [RATE_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [STEP_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: hdl/arc_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den.
// Depends on arc_pkg. A zero divisor gives a zero quotient.
module arc_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  arc_pkg::div_req_t req_i,
  output arc_pkg::div_rsp_t rsp_o
);
  import arc_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RATE_BITS-1:0] rem_q, rem_d;
  logic [STEP_W-1:0]    qr_q, qr_d;
  logic [RATE_BITS-1:0] den_q, den_d;
  logic                 zero_q, zero_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [RATE_BITS:0]   trial;
  logic                 ge;

  // The dividend is shifted out of the top of qr_q while quotient bits enter below.
  assign trial = {rem_q, qr_q[STEP_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qr_d   = qr_q;
    den_d  = den_q;
    zero_d = zero_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d  = DIV_CNT_W'(STEP_W);
      rem_d  = '0;
      qr_d   = {req_i.num, FRAC_BITS'(0)};
      den_d  = req_i.den;
      zero_d = (req_i.den == '0);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? RATE_BITS'(trial - {1'b0, den_q}) : trial[RATE_BITS-1:0];
      qr_d  = {qr_q[STEP_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    qr_q   <= qr_d;
    den_q  <= den_d;
    zero_q <= zero_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = zero_q ? '0 : qr_q;

endmodule

FILE: hdl/arc_interp.sv
// Interpolation of one channel between the previous and current sample.
// Depends on arc_pkg. Nearest picks by the top fraction bit, linear adds delta*f16 >> 16.
module arc_interp (
  input  logic signed [arc_pkg::SAMPLE_W-1:0] prev_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] cur_i,
  input  logic [arc_pkg::FRAC_BITS-1:0]       frac_i,
  input  arc_pkg::interp_mode_e               mode_i,
  output logic signed [arc_pkg::SAMPLE_W-1:0] sample_o
);
  import arc_pkg::*;

  logic signed [SAMPLE_W:0]       delta;
  logic signed [SAMPLE_W:0]       f16;
  logic signed [2*SAMPLE_W+1:0]   prod;
  logic signed [SAMPLE_W+1:0]     shifted;
  logic signed [SAMPLE_W+1:0]     sum;

  assign delta   = {cur_i[SAMPLE_W-1], cur_i} - {prev_i[SAMPLE_W-1], prev_i};
  assign f16     = {1'b0, frac_i[FRAC_BITS-1 -: SAMPLE_W]};
  assign prod    = delta * f16;
  // Dropping the low bits of a two's complement product rounds towards minus infinity.
  assign shifted = prod[2*SAMPLE_W+1:SAMPLE_W];
  assign sum     = {{2{prev_i[SAMPLE_W-1]}}, prev_i} + shifted;

  always_comb begin
    case (mode_i)
      MODE_NEAREST: sample_o = frac_i[FRAC_BITS-1] ? cur_i : prev_i;
      default:      sample_o = sum[SAMPLE_W-1:0];
    endcase
  end

endmodule

FILE: hdl/audio_rate_converter_core.sv
// Audio rate converter: linear or nearest resampling of mono or stereo 16-bit frames.
// A frame is taken while idle and moves the state to S_RUN, from which its results enter the
// output register one per cycle while the output is taken (at most 64).
// A restart or a first frame is absorbed without leaving idle. A rate write runs the divider
// and closes both inputs until the new step is loaded.
// Reset is asynchronous, active low: rates 48000, stereo, linear, phase and history cleared.
module audio_rate_converter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] right_in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [arc_pkg::SAMPLE_W-1:0] left_out_o,
  output logic signed [arc_pkg::SAMPLE_W-1:0] right_out_o,
  output logic                               run_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [arc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [arc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import arc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_RUN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [RATE_BITS-1:0] in_rate_q, in_rate_d;
  logic [RATE_BITS-1:0] out_rate_q, out_rate_d;
  logic [1:0]           chan_q, chan_d;
  interp_mode_e         mode_q, mode_d;

  logic [STEP_W-1:0]  step_q, step_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               have_q, have_d;
  logic               pass_q, pass_d;

  logic signed [SAMPLE_W-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic signed [SAMPLE_W-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic                       out_last_q, out_last_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                       mono;
  logic                       cfg_fire, in_fire, out_free;
  logic                       loop_ok, sum_ge_one, cap_hit, run_end;
  logic [PHASE_W-1:0]         phase_sum, fin_src, fin_phase;
  logic signed [SAMPLE_W-1:0] blend_l, blend_r;

  assign mono     = (chan_q == CHAN_MONO);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // A rate write restarts the divider on the new pair of rates.
  always_comb begin
    div_req.start = cfg_fire && ((cfg_index_i == REG_INPUT_RATE) ||
                                 (cfg_index_i == REG_OUTPUT_RATE));
    div_req.num   = (cfg_index_i == REG_INPUT_RATE) ? cfg_data_i : in_rate_q;
    div_req.den   = (cfg_index_i == REG_OUTPUT_RATE) ? cfg_data_i : out_rate_q;
  end

  arc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  arc_interp u_interp_l (
    .prev_i   (prev_l_q),
    .cur_i    (cur_l_q),
    .frac_i   (phase_q[FRAC_BITS-1:0]),
    .mode_i   (mode_q),
    .sample_o (blend_l)
  );

  arc_interp u_interp_r (
    .prev_i   (prev_r_q),
    .cur_i    (cur_r_q),
    .frac_i   (phase_q[FRAC_BITS-1:0]),
    .mode_i   (mode_q),
    .sample_o (blend_r)
  );

  assign phase_sum  = phase_q + {1'b0, step_q};
  assign loop_ok    = (phase_q[PHASE_W-1:FRAC_BITS] == '0) && (cnt_q < CNT_W'(MAX_OUTPUTS));
  assign sum_ge_one = (phase_sum[PHASE_W-1:FRAC_BITS] != '0);
  assign cap_hit    = (cnt_q == CNT_W'(MAX_OUTPUTS - 1));
  assign run_end    = sum_ge_one || cap_hit;
  // Closing a run takes one input period off the phase, or clears it if below one.
  assign fin_src    = loop_ok ? phase_sum : phase_q;
  assign fin_phase  = (fin_src[PHASE_W-1:FRAC_BITS] != '0) ? fin_src - PHASE_ONE : '0;

  always_comb begin
    state_d     = state_q;
    in_rate_d   = in_rate_q;
    out_rate_d  = out_rate_q;
    chan_d      = chan_q;
    mode_d      = mode_q;
    step_d      = step_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    have_d      = have_q;
    pass_d      = pass_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    cur_l_d     = cur_l_q;
    cur_r_d     = cur_r_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          unique case (cfg_index_i)
            REG_INPUT_RATE:    in_rate_d  = cfg_data_i;
            REG_OUTPUT_RATE:   out_rate_d = cfg_data_i;
            REG_CHANNEL_COUNT: chan_d     = cfg_data_i[1:0];
            REG_INTERP_MODE:   mode_d     = interp_mode_e'(cfg_data_i[0]);
            default:           ;
          endcase
          if (div_req.start) begin
            state_d = S_DIV;
          end
        end else if (in_fire) begin
          if (kind_i == KIND_RESTART) begin
            phase_d  = '0;
            prev_l_d = '0;
            prev_r_d = '0;
            have_d   = 1'b0;
          end else begin
            cur_l_d = left_in_i;
            cur_r_d = mono ? '0 : right_in_i;
            cnt_d   = '0;
            if (in_rate_q == out_rate_q) begin
              pass_d  = 1'b1;
              state_d = S_RUN;
            end else if (!have_q) begin
              prev_l_d = left_in_i;
              prev_r_d = mono ? '0 : right_in_i;
              have_d   = 1'b1;
            end else begin
              pass_d  = 1'b0;
              state_d = S_RUN;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          step_d  = (div_rsp.quot < STEP_MIN) ? STEP_MIN : div_rsp.quot;
          state_d = S_IDLE;
        end
      end
      S_RUN: begin
        if (pass_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_l_d     = cur_l_q;
            out_r_d     = cur_r_q;
            out_last_d  = 1'b1;
            phase_d     = '0;
            prev_l_d    = cur_l_q;
            prev_r_d    = cur_r_q;
            have_d      = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (!loop_ok) begin
          phase_d  = fin_phase;
          prev_l_d = cur_l_q;
          prev_r_d = cur_r_q;
          state_d  = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_l_d     = blend_l;
          out_r_d     = mono ? '0 : blend_r;
          out_last_d  = run_end;
          cnt_d       = cnt_q + CNT_W'(1);
          if (run_end) begin
            phase_d  = fin_phase;
            prev_l_d = cur_l_q;
            prev_r_d = cur_r_q;
            state_d  = S_IDLE;
          end else begin
            phase_d = phase_sum;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_rate_q   <= RATE_RESET;
      out_rate_q  <= RATE_RESET;
      chan_q      <= CHAN_RESET;
      mode_q      <= MODE_LINEAR;
      step_q      <= STEP_RESET;
      phase_q     <= '0;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      pass_q      <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_rate_q   <= in_rate_d;
      out_rate_q  <= out_rate_d;
      chan_q      <= chan_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      have_q      <= have_d;
      pass_q      <= pass_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_l_q    <= cur_l_d;
    cur_r_q    <= cur_r_d;
    out_l_q    <= out_l_d;
    out_r_q    <= out_r_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;
  assign run_last_o  = out_last_q;

endmodule

FILE: hdl/arc_checker.sv
// Port-level checks for the audio rate converter, bound to the top level.
// Depends on arc_pkg and audio_rate_converter_core.
module arc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               kind_i,
  input logic signed [arc_pkg::SAMPLE_W-1:0] left_in_i,
  input logic signed [arc_pkg::SAMPLE_W-1:0] right_in_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [arc_pkg::SAMPLE_W-1:0] left_out_o,
  input logic signed [arc_pkg::SAMPLE_W-1:0] right_out_o,
  input logic                               run_last_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [arc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input logic [arc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import arc_pkg::*;

  // A rate write starts the divider, so no frame may be taken on the next cycle.
  a_rate_write_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o &&
    (cfg_index_i == REG_INPUT_RATE || cfg_index_i == REG_OUTPUT_RATE)
    |=> !in_ready_o)
    else $error("frame input ready straight after a rate write");

  // Frames are only taken while the configuration port is open too.
  a_in_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> cfg_ready_o)
    else $error("frame input ready while configuration port closed");

  // While a result that is not the last of its run waits, the run is still going.
  a_run_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_last_o |-> !in_ready_o)
    else $error("new frame taken before the run was finished");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(left_out_o) &&
    $stable(right_out_o) && $stable(run_last_o))
    else $error("stalled result changed or dropped");

endmodule

bind audio_rate_converter_core arc_checker u_arc_checker (.*);

FILE: test/arc_converter_checker.sv
// Checker for the audio rate converter core: predicts every resampled frame and compares
// each output transfer with the oldest prediction. Depends on arc_pkg only.
module arc_converter_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               kind_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] left_in_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] right_in_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] left_out_i,
  input  logic signed [arc_pkg::SAMPLE_W-1:0] right_out_i,
  input  logic                               run_last_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [arc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [arc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import arc_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } out_frame_t;

  out_frame_t expected_frames[$];
  out_frame_t want;

  logic [RATE_BITS-1:0]       src_rate;
  logic [RATE_BITS-1:0]       dst_rate;
  logic [1:0]                 chan_cfg;
  interp_mode_e               mode;
  logic signed [SAMPLE_W-1:0] hist_left;
  logic signed [SAMPLE_W-1:0] hist_right;
  logic                       hist_valid;
  logic [63:0]                phase_acc;
  logic [63:0]                phase_step;
  int                         failures;
  int                         checked;

  function automatic logic [63:0] step_for(input logic [RATE_BITS-1:0] src,
                                           input logic [RATE_BITS-1:0] dst);
    logic [63:0] quot;
    quot = (dst == '0) ? 64'd0 : (64'(src) << FRAC_BITS) / 64'(dst);
    // Keep the step large enough that one frame never yields more than the result cap.
    return (quot < 64'(STEP_MIN)) ? 64'(STEP_MIN) : quot;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mix(input logic signed [SAMPLE_W-1:0] older,
                                                     input logic signed [SAMPLE_W-1:0] newer,
                                                     input logic [FRAC_BITS-1:0] frac,
                                                     input interp_mode_e m);
    longint prod;
    longint part;
    if (m == MODE_NEAREST) begin
      return frac[FRAC_BITS-1] ? newer : older;
    end
    prod = (longint'(newer) - longint'(older)) * longint'(frac[FRAC_BITS-1 -: 16]);
    // The scaled difference is floored, so a negative one rounds towards minus infinity.
    part = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
    return SAMPLE_W'(longint'(older) + part);
  endfunction

  task automatic resample_frame(input logic kind,
                                input logic signed [SAMPLE_W-1:0] left_raw,
                                input logic signed [SAMPLE_W-1:0] right_raw);
    logic                       mono;
    logic signed [SAMPLE_W-1:0] cur_left;
    logic signed [SAMPLE_W-1:0] cur_right;
    logic [63:0]                next_phase;
    int                         n;
    out_frame_t                 f;
    mono      = (chan_cfg == CHAN_MONO);
    cur_left  = left_raw;
    cur_right = mono ? '0 : right_raw;
    if (kind == KIND_RESTART) begin
      phase_acc  = '0;
      hist_left  = '0;
      hist_right = '0;
      hist_valid = 1'b0;
    end else if (src_rate == dst_rate) begin
      f.left  = cur_left;
      f.right = cur_right;
      f.last  = 1'b1;
      expected_frames.push_back(f);
      phase_acc  = '0;
      hist_left  = cur_left;
      hist_right = cur_right;
      hist_valid = 1'b1;
    end else if (!hist_valid) begin
      hist_left  = cur_left;
      hist_right = cur_right;
      hist_valid = 1'b1;
    end else begin
      n = 0;
      while (phase_acc[63:FRAC_BITS] == '0 && n < MAX_OUTPUTS) begin
        next_phase = (phase_acc > ~phase_step) ? '1 : phase_acc + phase_step;
        f.left  = mix(hist_left, cur_left, phase_acc[FRAC_BITS-1:0], mode);
        f.right = mono ? '0 : mix(hist_right, cur_right, phase_acc[FRAC_BITS-1:0], mode);
        f.last  = (next_phase[63:FRAC_BITS] != '0) || (n == MAX_OUTPUTS - 1);
        expected_frames.push_back(f);
        phase_acc = next_phase;
        n++;
      end
      phase_acc  = (phase_acc >= 64'(PHASE_ONE)) ? phase_acc - 64'(PHASE_ONE) : '0;
      hist_left  = cur_left;
      hist_right = cur_right;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate   = RATE_RESET;
      dst_rate   = RATE_RESET;
      chan_cfg   = CHAN_RESET;
      mode       = MODE_LINEAR;
      hist_left  = '0;
      hist_right = '0;
      hist_valid = 1'b0;
      phase_acc  = '0;
      phase_step = step_for(RATE_RESET, RATE_RESET);
      expected_frames.delete();
      failures   = 0;
      checked    = 0;
    end else begin
      // A result never leaves at the edge that takes its own frame, so the output is
      // checked first.
      if (out_valid_i && out_ready_i) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected result: left_out %0d right_out %0d run_last %0b",
                 left_out_i, right_out_i, run_last_i);
          failures++;
        end else begin
          want = expected_frames.pop_front();
          checked++;
          if (left_out_i !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out_i);
            failures++;
          end
          if (right_out_i !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out_i);
            failures++;
          end
          if (run_last_i !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, run_last_i);
            failures++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_INPUT_RATE: begin
            src_rate   = cfg_data_i[RATE_BITS-1:0];
            phase_step = step_for(src_rate, dst_rate);
          end
          REG_OUTPUT_RATE: begin
            dst_rate   = cfg_data_i[RATE_BITS-1:0];
            phase_step = step_for(src_rate, dst_rate);
          end
          REG_CHANNEL_COUNT: chan_cfg = cfg_data_i[1:0];
          REG_INTERP_MODE:   mode = interp_mode_e'(cfg_data_i[0]);
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        resample_frame(kind_i, left_in_i, right_in_i);
      end
    end
    pending_o    <= expected_frames.size();
    fail_count_o <= failures;
    checked_o    <= checked;
  end

endmodule

FILE: test/audio_rate_converter_core_tb.sv
// Testbench top for audio_rate_converter_core: drives frames, register writes and output
// back-pressure, then gives the verdict. Depends on it, arc_pkg and arc_converter_checker.
module audio_rate_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arc_pkg::*;

  localparam int MAX_GAP       = 17;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 2000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_kind   = KIND_FRAME;
  logic [SAMPLE_W-1:0]   in_left   = '0;
  logic [SAMPLE_W-1:0]   in_right  = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_last;
  logic                  cfg_ready;
  logic [SAMPLE_W-1:0]   out_left;
  logic [SAMPLE_W-1:0]   out_right;

  int fail_count;
  int pending;
  int checked;
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_off_req  = 1'b0;
  int frames_sent   = 0;
  int restarts_sent = 0;
  int reg_writes    = 0;
  int settings      = 1;

  audio_rate_converter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (in_kind),
    .left_in_i   (in_left),
    .right_in_i  (in_right),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .left_out_o  (out_left),
    .right_out_o (out_right),
    .run_last_o  (out_last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  arc_converter_checker resample_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (in_kind),
    .left_in_i    (in_left),
    .right_in_i   (in_right),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .left_out_i   (out_left),
    .right_out_i  (out_right),
    .run_last_i   (out_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RATE_BITS-1:0] pick_rate();
    case ($urandom_range(0, 11))
      0:       return 24'd8000;
      1:       return 24'd11025;
      2:       return 24'd16000;
      3:       return 24'd22050;
      4:       return 24'd32000;
      5:       return 24'd44100;
      6:       return 24'd48000;
      7:       return 24'd96000;
      8:       return 24'd192000;
      9:       return RATE_BITS'($urandom_range(1, 64));
      10:      return RATE_BITS'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? {RATE_BITS{1'b1}} : RATE_BITS'(0);
    endcase
  endfunction

  // Valid is left high after a transfer so that a back-to-back frame follows with no gap on valid.
  task automatic offer_frame(input item_kind_e kind, input logic [SAMPLE_W-1:0] left,
                             input logic [SAMPLE_W-1:0] right);
    int gap;
    gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_left  <= left;
    in_right <= right;
    do @(posedge clk); while (!in_ready);
    if (kind == KIND_RESTART) restarts_sent++;
    else frames_sent++;
  endtask

  // Frames that give no result may still be in flight, hence the settling cycles.
  task automatic drain_converter();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [RATE_BITS-1:0] src, input logic [RATE_BITS-1:0] dst,
                                input logic [1:0] chan, input interp_mode_e mode);
    drain_converter();
    write_register(REG_INPUT_RATE, src);
    write_register(REG_OUTPUT_RATE, dst);
    write_register(REG_CHANNEL_COUNT, CFG_DATA_W'(chan));
    write_register(REG_INTERP_MODE, CFG_DATA_W'(mode));
    settings++;
  endtask

  initial begin : receiver
    int stall;
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      stall = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !hold_off_req);
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no transfer for %0d cycles.", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Equal rates out of reset: each frame passes straight through.
    offer_frame(KIND_FRAME, 16'h7fff, 16'h8000);
    offer_frame(KIND_FRAME, 16'h8000, 16'h7fff);
    offer_frame(KIND_FRAME, 16'h0000, 16'hffff);
    offer_frame(KIND_RESTART, 16'h1234, 16'h5678);
    offer_frame(KIND_FRAME, 16'h0001, 16'h0000);

    // Twofold upsampling; after the restart the first frame only becomes history.
    apply_settings(24'd1, 24'd2, 2'd2, MODE_LINEAR);
    offer_frame(KIND_RESTART, pick_sample(), pick_sample());
    offer_frame(KIND_FRAME, 16'h8000, 16'h7fff);
    offer_frame(KIND_FRAME, 16'h7fff, 16'h8000);
    offer_frame(KIND_FRAME, 16'h0000, 16'h0000);
    offer_frame(KIND_FRAME, 16'h8000, 16'h8000);

    // Mono nearest pick; a fraction of exactly one half selects the newer frame.
    apply_settings(24'd1, 24'd2, CHAN_MONO, MODE_NEAREST);
    repeat (4) offer_frame(KIND_FRAME, pick_sample(), pick_sample());

    // Downsampling by three, where a channel count of zero still means stereo.
    apply_settings(24'd3, 24'd1, 2'd0, MODE_LINEAR);
    repeat (4) offer_frame(KIND_FRAME, pick_sample(), pick_sample());

    // A zero output rate forces the smallest step, so the cap of results is reached.
    apply_settings({RATE_BITS{1'b1}}, 24'd0, 2'd3, MODE_LINEAR);
    offer_frame(KIND_RESTART, pick_sample(), pick_sample());
    offer_frame(KIND_FRAME, 16'h8000, 16'h7fff);
    offer_frame(KIND_FRAME, 16'h7fff, 16'h8000);
    offer_frame(KIND_FRAME, pick_sample(), pick_sample());

    // Two zero rates count as equal rates.
    apply_settings(24'd0, 24'd0, 2'd2, MODE_NEAREST);
    repeat (2) offer_frame(KIND_FRAME, pick_sample(), pick_sample());

    // The largest step leaves the phase far above one until a restart.
    apply_settings({RATE_BITS{1'b1}}, 24'd1, CHAN_MONO, MODE_LINEAR);
    repeat (2) offer_frame(KIND_FRAME, pick_sample(), pick_sample());
    offer_frame(KIND_RESTART, pick_sample(), pick_sample());

    // Hold the output off while frames keep coming, so the input side has to stall.
    apply_settings(24'd8000, 24'd48000, 2'd2, MODE_LINEAR);
    sender_idle  = 1'b0;
    hold_off_req = 1'b1;
    repeat (12) offer_frame(KIND_FRAME, pick_sample(), pick_sample());
    drain_converter();

    for (int p = 0; p < 8; p++) begin
      apply_settings(pick_rate(), pick_rate(), 2'($urandom_range(0, 3)),
                     interp_mode_e'($urandom_range(0, 1)));
      sender_idle   = (p % 4 != 0);
      receiver_idle = (p % 3 != 0);
      if ($urandom_range(0, 3) != 0) offer_frame(KIND_RESTART, pick_sample(), pick_sample());
      repeat (20) begin
        if ($urandom_range(0, 15) == 0)
          offer_frame(KIND_RESTART, pick_sample(), pick_sample());
        else
          offer_frame(KIND_FRAME, pick_sample(), pick_sample());
        if ($urandom_range(0, 24) == 0) drain_converter();
      end
    end

    drain_converter();
    $display("Covered %0d frames and %0d restarts under %0d settings with %0d register writes.",
             frames_sent, restarts_sent, settings, reg_writes);
    $display("Compared %0d output frames, %0d mismatches.", checked, fail_count);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
